// ----- sv/hstr_pkg.sv -----
`timescale 1ns / 1ps

package hstr_pkg;

    localparam int FULL_SCALE_DEF = 65535;

    // hue circle is cut into six equal segments, channels sit four segments apart
    localparam int SEG_COUNT   = 6;
    localparam int CH_SPACING  = 4;

    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;

    // trapezoid segments; indices 0 and 5, and any index not listed here, hold the peak
    localparam logic [15:0] SEG_FALL    = 16'd1;
    localparam logic [15:0] SEG_FLOOR_A = 16'd2;
    localparam logic [15:0] SEG_FLOOR_B = 16'd3;
    localparam logic [15:0] SEG_RISE    = 16'd4;

    // travels alongside the hue segment divide
    typedef struct packed {
        logic [31:0] prod;
        logic [15:0] lit;
        logic [15:0] sat;
    } seg_side_t;

    // travels alongside the full scale divide
    typedef struct packed {
        logic [15:0] lit;
        logic [15:0] sat;
        logic [15:0] seg;
        logic [15:0] frac;
    } fs_side_t;

    // travels alongside the ramp step divide
    typedef struct packed {
        logic [15:0] hi;
        logic [15:0] lo;
        logic [15:0] seg;
    } step_side_t;

endpackage

// ----- sv/hstr_front.sv -----
`timescale 1ns / 1ps

module hstr_front
    import hstr_pkg::*;
#(
    parameter int FULL_SCALE = FULL_SCALE_DEF,
    parameter int SEG_LEN    = (FULL_SCALE_DEF + 1) / SEG_COUNT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] hue,
    input  logic [15:0] saturation,
    input  logic [15:0] lightness,
    input  logic [1:0]  channel,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] pos,
    output seg_side_t   side
);

    localparam logic [15:0] FS_C   = 16'(FULL_SCALE);
    localparam logic [15:0] OFF_G  = 16'(CH_SPACING * SEG_LEN);
    localparam logic [15:0] OFF_B  = 16'(2 * CH_SPACING * SEG_LEN);
    localparam logic [15:0] OFF_X  = 16'(3 * CH_SPACING * SEG_LEN);

    logic        v_reg;
    logic        v_next;
    logic [15:0] pos_reg;
    logic [15:0] pos_next;
    seg_side_t   side_reg;
    seg_side_t   side_next;
    logic [15:0] sat_c;
    logic [15:0] lit_c;
    logic [15:0] offset;

    assign in_ready = !v_reg || out_ready;

    always_comb
    begin
        sat_c = (saturation > FS_C) ? FS_C : saturation;
        lit_c = (lightness > FS_C) ? FS_C : lightness;
        case (channel)
            CH_RED:   offset = 16'd0;
            CH_GREEN: offset = OFF_G;
            CH_BLUE:  offset = OFF_B;
            default:  offset = OFF_X;
        endcase
        pos_next       = hue + offset;
        side_next.prod = lit_c * sat_c;
        side_next.lit  = lit_c;
        side_next.sat  = sat_c;
        v_next         = in_ready ? in_valid : v_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            pos_reg  <= pos_next;
            side_reg <= side_next;
        end
    end

    assign out_valid = v_reg;
    assign pos       = pos_reg;
    assign side      = side_reg;

endmodule

// ----- sv/hstr_cdiv.sv -----
`timescale 1ns / 1ps

module hstr_cdiv
    import hstr_pkg::*;
#(
    parameter int NUM_W   = 32,
    parameter int DIVISOR = (FULL_SCALE_DEF + 1) / SEG_COUNT,
    parameter int SIDE_W  = 48
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [NUM_W-1:0]  x,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [NUM_W-1:0]  quot,
    output logic [NUM_W-1:0]  rem,
    output logic [SIDE_W-1:0] side_out
);

    localparam int HALF_W = NUM_W / 2;
    localparam int HI_W   = NUM_W - HALF_W;
    // reciprocal rounded down, so the estimate is low by at most one
    localparam logic [NUM_W-1:0] RECIP = NUM_W'((65'd1 << NUM_W) / DIVISOR);
    localparam logic [NUM_W-1:0] DIV_C = NUM_W'(DIVISOR);

    logic [3:0] v_reg;
    logic [3:0] v_next;
    logic [3:0] stage_rdy;

    // partial products
    logic [NUM_W-1:0]        x_a_reg;
    logic [HI_W+NUM_W-1:0]   pph_reg;
    logic [HI_W+NUM_W-1:0]   pph_next;
    logic [HALF_W+NUM_W-1:0] ppl_reg;
    logic [HALF_W+NUM_W-1:0] ppl_next;
    logic [SIDE_W-1:0]       side_a_reg;
    // quotient estimate
    logic [2*NUM_W-1:0]      sum;
    logic [NUM_W-1:0]        x_b_reg;
    logic [NUM_W-1:0]        qe_b_reg;
    logic [SIDE_W-1:0]       side_b_reg;
    // back product
    logic [NUM_W-1:0]        x_c_reg;
    logic [NUM_W-1:0]        qe_c_reg;
    logic [NUM_W-1:0]        qd_reg;
    logic [NUM_W-1:0]        qd_next;
    logic [SIDE_W-1:0]       side_c_reg;
    // corrected result
    logic [NUM_W-1:0]        r_est;
    logic [NUM_W-1:0]        quot_reg;
    logic [NUM_W-1:0]        quot_next;
    logic [NUM_W-1:0]        rem_reg;
    logic [NUM_W-1:0]        rem_next;
    logic [SIDE_W-1:0]       side_d_reg;

    always_comb
    begin
        stage_rdy[3] = !v_reg[3] || out_ready;
        stage_rdy[2] = !v_reg[2] || stage_rdy[3];
        stage_rdy[1] = !v_reg[1] || stage_rdy[2];
        stage_rdy[0] = !v_reg[0] || stage_rdy[1];
        v_next[0] = stage_rdy[0] ? in_valid : v_reg[0];
        v_next[1] = stage_rdy[1] ? v_reg[0] : v_reg[1];
        v_next[2] = stage_rdy[2] ? v_reg[1] : v_reg[2];
        v_next[3] = stage_rdy[3] ? v_reg[2] : v_reg[3];
    end

    assign in_ready = stage_rdy[0];

    always_comb
    begin
        pph_next = x[NUM_W-1:HALF_W] * RECIP;
        ppl_next = x[HALF_W-1:0] * RECIP;
        sum      = {pph_reg, {HALF_W{1'b0}}} + (2*NUM_W)'(ppl_reg);
        qd_next  = qe_b_reg * DIV_C;
        r_est    = x_c_reg - qd_reg;
        if (r_est >= DIV_C)
        begin
            quot_next = qe_c_reg + NUM_W'(1);
            rem_next  = r_est - DIV_C;
        end
        else
        begin
            quot_next = qe_c_reg;
            rem_next  = r_est;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_rdy[0])
        begin
            x_a_reg    <= x;
            pph_reg    <= pph_next;
            ppl_reg    <= ppl_next;
            side_a_reg <= side_in;
        end
        if (stage_rdy[1])
        begin
            x_b_reg    <= x_a_reg;
            qe_b_reg   <= sum[2*NUM_W-1:NUM_W];
            side_b_reg <= side_a_reg;
        end
        if (stage_rdy[2])
        begin
            x_c_reg    <= x_b_reg;
            qe_c_reg   <= qe_b_reg;
            qd_reg     <= qd_next;
            side_c_reg <= side_b_reg;
        end
        if (stage_rdy[3])
        begin
            quot_reg   <= quot_next;
            rem_reg    <= rem_next;
            side_d_reg <= side_c_reg;
        end
    end

    assign out_valid = v_reg[3];
    assign quot      = quot_reg;
    assign rem       = rem_reg;
    assign side_out  = side_d_reg;

endmodule

// ----- sv/hstr_level.sv -----
`timescale 1ns / 1ps

module hstr_level
    import hstr_pkg::*;
#(
    parameter int FULL_SCALE = FULL_SCALE_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] quot,
    input  logic [31:0] rem,
    input  fs_side_t    side_in,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] prod,
    output step_side_t  side_out
);

    localparam logic [15:0] FS_C   = 16'(FULL_SCALE);
    localparam logic [15:0] HALF_C = 16'(FULL_SCALE / 2);

    logic [2:0]  v_reg;
    logic [2:0]  v_next;
    logic [2:0]  stage_rdy;

    // peak level
    logic [17:0] hi_raw;
    logic [15:0] hi_a_reg;
    logic [15:0] hi_a_next;
    logic [15:0] lit_a_reg;
    logic [15:0] seg_a_reg;
    logic [15:0] frac_a_reg;
    // floor level and swing
    logic [16:0] two_l;
    logic [16:0] lo_raw;
    logic [15:0] lo_next;
    logic [15:0] hi_b_reg;
    logic [15:0] lo_b_reg;
    logic [15:0] diff_b_reg;
    logic [15:0] seg_b_reg;
    logic [15:0] frac_b_reg;
    // swing times position in segment
    logic [31:0] prod_reg;
    logic [31:0] prod_next;
    step_side_t  side_c_reg;

    always_comb
    begin
        stage_rdy[2] = !v_reg[2] || out_ready;
        stage_rdy[1] = !v_reg[1] || stage_rdy[2];
        stage_rdy[0] = !v_reg[0] || stage_rdy[1];
        v_next[0] = stage_rdy[0] ? in_valid : v_reg[0];
        v_next[1] = stage_rdy[1] ? v_reg[0] : v_reg[1];
        v_next[2] = stage_rdy[2] ? v_reg[1] : v_reg[2];
    end

    assign in_ready = stage_rdy[0];

    always_comb
    begin
        // quot is lit*sat/FS; rem flags the rounding of the upper formula
        if (side_in.lit < HALF_C)
        begin
            hi_raw = 18'(side_in.lit) + 18'(quot[15:0]);
        end
        else
        begin
            hi_raw = 18'(side_in.lit) + 18'(side_in.sat) - 18'(quot[15:0])
                     - 18'(rem != 32'd0);
        end
        hi_a_next = (hi_raw > 18'(FS_C)) ? FS_C : hi_raw[15:0];

        two_l  = {lit_a_reg, 1'b0};
        lo_raw = (two_l > 17'(hi_a_reg)) ? two_l - 17'(hi_a_reg) : 17'd0;
        lo_next = (lo_raw > 17'(hi_a_reg)) ? hi_a_reg : lo_raw[15:0];

        prod_next = diff_b_reg * frac_b_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_rdy[0])
        begin
            hi_a_reg   <= hi_a_next;
            lit_a_reg  <= side_in.lit;
            seg_a_reg  <= side_in.seg;
            frac_a_reg <= side_in.frac;
        end
        if (stage_rdy[1])
        begin
            hi_b_reg   <= hi_a_reg;
            lo_b_reg   <= lo_next;
            diff_b_reg <= hi_a_reg - lo_next;
            seg_b_reg  <= seg_a_reg;
            frac_b_reg <= frac_a_reg;
        end
        if (stage_rdy[2])
        begin
            prod_reg       <= prod_next;
            side_c_reg.hi  <= hi_b_reg;
            side_c_reg.lo  <= lo_b_reg;
            side_c_reg.seg <= seg_b_reg;
        end
    end

    assign out_valid = v_reg[2];
    assign prod      = prod_reg;
    assign side_out  = side_c_reg;

endmodule

// ----- sv/hsl_to_rgb_channel.sv -----
`timescale 1ns / 1ps

// HSL to RGB conversion for one color channel per transaction. Each transaction carries a
// 16-bit hue, saturation and lightness (lightness already on its perceptual scale) and a
// channel select (0 red, 1 green, 2 blue) and returns that channel's 16-bit level.
// Saturation and lightness above FULL_SCALE are clamped. Peak and floor levels are derived
// from lightness and saturation with a split at half scale; the level then follows a
// six-segment trapezoid over hue, each channel offset by four segments (mod 65536). Zero
// saturation falls out of the same arithmetic as level equal to lightness. The block is a
// 17-stage pipeline that accepts one transaction per clock while out_ready stays high.
// All divisions are by constants (FULL_SCALE and the segment length) and run as
// reciprocal-multiply-and-correct units of four stages each. Backpressure ripples stage
// by stage, so empty stages keep filling while a result waits on the output.

module hsl_to_rgb_channel
    import hstr_pkg::*;
#(
    parameter int FULL_SCALE = FULL_SCALE_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] hue,
    input  logic [15:0] saturation,
    input  logic [15:0] lightness,
    input  logic [1:0]  channel,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] level
);

    localparam int SEG_LEN = (FULL_SCALE + 1) / SEG_COUNT;

    // front: clamp, lightness*saturation product, per-channel hue offset
    logic        fr_valid;
    logic        fr_ready;
    logic [15:0] fr_pos;
    seg_side_t   fr_side;

    // hue position split into segment index and offset inside the segment
    logic        sg_valid;
    logic        sg_ready;
    logic [15:0] sg_quot;
    logic [15:0] sg_rem;
    seg_side_t   sg_side;
    fs_side_t    fs_in_side;

    // lightness*saturation / FULL_SCALE
    logic        fs_valid;
    logic        fs_ready;
    logic [31:0] fs_quot;
    logic [31:0] fs_rem;
    fs_side_t    fs_side;

    // peak, floor and ramp numerator
    logic        lv_valid;
    logic        lv_ready;
    logic [31:0] lv_prod;
    step_side_t  lv_side;

    // ramp step = swing * offset / segment length
    logic        st_valid;
    logic        st_ready;
    logic [31:0] st_quot;
    logic [31:0] st_rem;
    step_side_t  st_side;

    // output register
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [15:0] level_reg;
    logic [15:0] level_next;
    logic [15:0] step;

    hstr_front #(
        .FULL_SCALE (FULL_SCALE),
        .SEG_LEN    (SEG_LEN)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .hue        (hue),
        .saturation (saturation),
        .lightness  (lightness),
        .channel    (channel),
        .out_valid  (fr_valid),
        .out_ready  (fr_ready),
        .pos        (fr_pos),
        .side       (fr_side)
    );

    hstr_cdiv #(
        .NUM_W   (16),
        .DIVISOR (SEG_LEN),
        .SIDE_W  ($bits(seg_side_t))
    ) u_seg_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fr_valid),
        .in_ready  (fr_ready),
        .x         (fr_pos),
        .side_in   (fr_side),
        .out_valid (sg_valid),
        .out_ready (sg_ready),
        .quot      (sg_quot),
        .rem       (sg_rem),
        .side_out  (sg_side)
    );

    always_comb
    begin
        fs_in_side.lit  = sg_side.lit;
        fs_in_side.sat  = sg_side.sat;
        fs_in_side.seg  = sg_quot;
        fs_in_side.frac = sg_rem;
    end

    hstr_cdiv #(
        .NUM_W   (32),
        .DIVISOR (FULL_SCALE),
        .SIDE_W  ($bits(fs_side_t))
    ) u_fs_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sg_valid),
        .in_ready  (sg_ready),
        .x         (sg_side.prod),
        .side_in   (fs_in_side),
        .out_valid (fs_valid),
        .out_ready (fs_ready),
        .quot      (fs_quot),
        .rem       (fs_rem),
        .side_out  (fs_side)
    );

    hstr_level #(
        .FULL_SCALE (FULL_SCALE)
    ) u_level (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fs_valid),
        .in_ready  (fs_ready),
        .quot      (fs_quot),
        .rem       (fs_rem),
        .side_in   (fs_side),
        .out_valid (lv_valid),
        .out_ready (lv_ready),
        .prod      (lv_prod),
        .side_out  (lv_side)
    );

    hstr_cdiv #(
        .NUM_W   (32),
        .DIVISOR (SEG_LEN),
        .SIDE_W  ($bits(step_side_t))
    ) u_step_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (lv_valid),
        .in_ready  (lv_ready),
        .x         (lv_prod),
        .side_in   (lv_side),
        .out_valid (st_valid),
        .out_ready (st_ready),
        .quot      (st_quot),
        .rem       (st_rem),
        .side_out  (st_side)
    );

    // the remainder of the ramp divide carries no information for the level
    assign st_ready = !out_valid_reg || out_ready;

    always_comb
    begin
        // step never exceeds the swing, so it fits 16 bits
        step = st_quot[15:0];
        case (st_side.seg)
            SEG_FALL:    level_next = st_side.hi - step;
            SEG_FLOOR_A,
            SEG_FLOOR_B: level_next = st_side.lo;
            SEG_RISE:    level_next = st_side.lo + step;
            default:     level_next = st_side.hi;
        endcase
        out_valid_next = st_ready ? st_valid : out_valid_reg;
        if (st_rem == 32'd0)
        begin
            level_next = level_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (st_ready)
        begin
            level_reg <= level_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign level     = level_reg;

endmodule
